FILE: rtl/cms_pkg.sv
// Shared types and constants for the chamfer template scoring block.
// No dependencies; imported by the interfaces and all modules.
`default_nettype none

package cms_pkg;

  // Field widths of the item and result beats
  localparam int MODE_W   = 2;
  localparam int PIXEL_W  = 16;
  localparam int QPOS_W   = 6;
  localparam int SCORE_W  = 26;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  // Item modes
  localparam logic [MODE_W-1:0] MODE_MODEL = 2'd0;
  localparam logic [MODE_W-1:0] MODE_IMAGE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COLS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MODEL_ROWS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MODEL_COLS = 2'd3;

  // Score saturates at the top of its field
  localparam logic [SCORE_W-1:0] SCORE_MAX = '1;

endpackage

`default_nettype wire

FILE: rtl/cms_in_if.sv
// Item channel for the chamfer scoring block: valid/ready plus item payload.
// Depends on cms_pkg for field widths.
`default_nettype none

interface cms_in_if import cms_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [PIXEL_W-1:0] pixel;
  logic [QPOS_W-1:0] query_row;
  logic [QPOS_W-1:0] query_col;

  modport source (output valid, mode, pixel, query_row, query_col, input ready);
  modport sink   (input valid, mode, pixel, query_row, query_col, output ready);
endinterface

`default_nettype wire

FILE: rtl/cms_out_if.sv
// Result channel for the chamfer scoring block: valid/ready plus score payload.
// Depends on cms_pkg for field widths.
`default_nettype none

interface cms_out_if import cms_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [SCORE_W-1:0] score;
  logic               placement_invalid;

  modport source (output valid, score, placement_invalid, input ready);
  modport sink   (input valid, score, placement_invalid, output ready);
endinterface

`default_nettype wire

FILE: rtl/chamfer_match_score.sv
// Chamfer template scoring. Model pixel: after a register write, the load position
// is first re-split into row and column, one model row per step. Score query: one
// walk over the point list through the single read/address/add pipeline (skipped
// when the model box does not fit), plus any wait for the result register to drain.
// One item at a time; a pending result does not block loads. Reset (sync, high):
// registers to 64/64/32/32, positions and count to zero.
`default_nettype none

module chamfer_match_score import cms_pkg::*; #(
  parameter int MAX_IMAGE_SIDE = 64,
  parameter int MAX_MODEL_SIDE = 32,
  parameter int DISTANCE_BITS  = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  cms_in_if.sink                     item,
  cms_out_if.source                  result,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int MODEL_CAP = MAX_MODEL_SIDE * MAX_MODEL_SIDE;
  localparam int IMAGE_CAP = MAX_IMAGE_SIDE * MAX_IMAGE_SIDE;
  localparam int MW   = $clog2(MAX_MODEL_SIDE);
  localparam int MSW  = $clog2(MAX_MODEL_SIDE + 1);
  localparam int ISW  = $clog2(MAX_IMAGE_SIDE + 1);
  localparam int LAW  = $clog2(MODEL_CAP);
  localparam int CW   = $clog2(MODEL_CAP + 1);
  localparam int IAW  = $clog2(IMAGE_CAP);
  localparam int ITW  = $clog2(IMAGE_CAP + 1);
  localparam int PW   = ((MW > QPOS_W) ? MW : QPOS_W) + 1;
  localparam int CMPW = (PW > ISW) ? PW : ISW;
  localparam int FW0  = (QPOS_W > ISW) ? QPOS_W : ISW;
  localparam int FW   = ((FW0 > MSW) ? FW0 : MSW) + 1;
  localparam int SUMW = ((DISTANCE_BITS > SCORE_W) ? DISTANCE_BITS : SCORE_W) + 1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MLOAD, ST_MDIV, ST_MADD, ST_ILOAD, ST_QCHK, ST_QRUN, ST_QOUT
  } state_t;

  // Configuration
  logic [ISW-1:0] irows;
  logic [ISW-1:0] icols;
  logic [MSW-1:0] mrows;
  logic [MSW-1:0] mcols;
  logic [ITW-1:0] itotal;
  logic [CW-1:0]  mtotal;

  cms_cfg_regs #(
    .MAX_IMAGE_SIDE (MAX_IMAGE_SIDE),
    .MAX_MODEL_SIDE (MAX_MODEL_SIDE)
  ) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cfg_wr_en),
    .wr_idx  (cfg_index),
    .wr_data (cfg_data),
    .irows   (irows),
    .icols   (icols),
    .mrows   (mrows),
    .mcols   (mcols),
    .itotal  (itotal),
    .mtotal  (mtotal)
  );

  state_t               state;
  logic [PIXEL_W-1:0]   pixel_q;
  logic [QPOS_W-1:0]    qrow_q;
  logic [QPOS_W-1:0]    qcol_q;

  // Model load position, kept linear and split into row and column
  logic [LAW-1:0]       mpos;
  logic [MW-1:0]        mrow;
  logic [MW-1:0]        mcol;
  logic [LAW-1:0]       rem;
  logic                 dec_ok;
  logic [CW-1:0]        mcount;

  // Image load position
  logic [IAW-1:0]       ipos;
  logic [IAW-1:0]       ipos_eff;
  logic [IAW-1:0]       ipos_next;

  // Query pipeline
  logic [CW-1:0]        qi;
  logic                 issue;
  logic                 v1;
  logic                 v2;
  logic                 v3;
  logic                 bad;
  logic [SCORE_W-1:0]   sum;
  logic [SCORE_W-1:0]   sum_next;
  logic [SUMW-1:0]      sum_wide;
  logic [IAW-1:0]       addr_q;
  logic [IAW-1:0]       addr_next;
  logic [PW-1:0]        pr;
  logic [PW-1:0]        pc;
  logic                 oob;
  logic                 fit_bad;

  // Result register
  logic                 out_valid;
  logic [SCORE_W-1:0]   out_score;
  logic                 out_invalid;

  // Memories
  logic [2*MW-1:0]          list_mem [MODEL_CAP];
  logic [2*MW-1:0]          list_q;
  logic                     list_we;
  logic [DISTANCE_BITS-1:0] dist_mem [IMAGE_CAP];
  logic [DISTANCE_BITS-1:0] dist_q;
  logic                     dist_we;

  assign item.ready               = (state == ST_IDLE);
  assign result.valid             = out_valid;
  assign result.score             = out_score;
  assign result.placement_invalid = out_invalid;

  // Image write address with wrap
  always_comb begin
    ipos_eff  = (ITW'(ipos) >= itotal) ? '0 : ipos;
    ipos_next = ((ITW'(ipos_eff) + ITW'(1)) >= itotal) ? '0 : (ipos_eff + IAW'(1));
  end

  assign list_we = (state == ST_MADD) && (pixel_q != '0) && (32'(mcount) < MODEL_CAP);
  assign dist_we = (state == ST_ILOAD);

  // Point placement, bound check and image address
  always_comb begin
    pr        = PW'(qrow_q) + PW'(list_q[2*MW-1:MW]);
    pc        = PW'(qcol_q) + PW'(list_q[MW-1:0]);
    oob       = (CMPW'(pr) >= CMPW'(irows)) || (CMPW'(pc) >= CMPW'(icols));
    addr_next = (IAW'(pr) * IAW'(icols)) + IAW'(pc);
    fit_bad   = ((FW'(qrow_q) + FW'(mrows)) > FW'(irows)) ||
                ((FW'(qcol_q) + FW'(mcols)) > FW'(icols));
    issue     = (state == ST_QRUN) && (qi < mcount);
    sum_wide  = SUMW'(sum) + SUMW'(dist_q);
    sum_next  = (sum_wide > SUMW'(SCORE_MAX)) ? SCORE_MAX : sum_wide[SCORE_W-1:0];
  end

  // Point list store
  always_ff @(posedge clk) begin
    if (list_we) begin
      list_mem[mcount[LAW-1:0]] <= {mrow, mcol};
    end
    list_q <= list_mem[qi[LAW-1:0]];
  end

  // Distance store
  always_ff @(posedge clk) begin
    if (dist_we) begin
      dist_mem[ipos_eff] <= DISTANCE_BITS'(pixel_q);
    end
    dist_q <= dist_mem[addr_q];
  end

  // Sequencer, datapath and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      mpos      <= '0;
      mrow      <= '0;
      mcol      <= '0;
      dec_ok    <= 1'b1;
      mcount    <= '0;
      ipos      <= '0;
      qi        <= '0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      bad       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // Drop the result once the beat is taken, unless a new score replaces it
      if (out_valid && result.ready && (state != ST_QOUT)) begin
        out_valid <= 1'b0;
      end
      // A register write may move the row/column split of the load position
      if (cfg_wr_en && (state != ST_MLOAD) && (state != ST_MDIV)) begin
        dec_ok <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (item.valid) begin
            pixel_q <= item.pixel;
            qrow_q  <= item.query_row;
            qcol_q  <= item.query_col;
            case (item.mode)
              MODE_MODEL: state <= ST_MLOAD;
              MODE_IMAGE: state <= ST_ILOAD;
              MODE_QUERY: state <= ST_QCHK;
              default:    state <= ST_IDLE;
            endcase
          end
        end
        // Wrap the position; a pixel at position zero starts a new model
        ST_MLOAD: begin
          if ((CW'(mpos) >= mtotal) || (mpos == '0)) begin
            mpos   <= '0;
            mrow   <= '0;
            mcol   <= '0;
            dec_ok <= 1'b1;
            mcount <= '0;
            state  <= ST_MADD;
          end else if (dec_ok) begin
            state <= ST_MADD;
          end else begin
            rem   <= mpos;
            mrow  <= '0;
            state <= ST_MDIV;
          end
        end
        // Split the position into row and column, one row per step
        ST_MDIV: begin
          if (CW'(rem) >= CW'(mcols)) begin
            rem  <= rem - LAW'(mcols);
            mrow <= mrow + MW'(1);
          end else begin
            mcol   <= MW'(rem);
            dec_ok <= 1'b1;
            state  <= ST_MADD;
          end
        end
        // Append the point and advance the position
        ST_MADD: begin
          if (list_we) begin
            mcount <= mcount + CW'(1);
          end
          if ((CW'(mpos) + CW'(1)) >= mtotal) begin
            mpos <= '0;
            mrow <= '0;
            mcol <= '0;
          end else begin
            mpos <= mpos + LAW'(1);
            if ((MSW'(mcol) + MSW'(1)) == mcols) begin
              mcol <= '0;
              mrow <= mrow + MW'(1);
            end else begin
              mcol <= mcol + MW'(1);
            end
          end
          state <= ST_IDLE;
        end
        ST_ILOAD: begin
          ipos  <= ipos_next;
          state <= ST_IDLE;
        end
        // Check that the model box fits, then start the point walk
        ST_QCHK: begin
          qi  <= '0;
          v1  <= 1'b0;
          v2  <= 1'b0;
          v3  <= 1'b0;
          sum <= '0;
          bad <= fit_bad;
          state <= fit_bad ? ST_QOUT : ST_QRUN;
        end
        // Read point, form address, read distance, accumulate
        ST_QRUN: begin
          v1 <= issue;
          if (issue) begin
            qi <= qi + CW'(1);
          end
          if (v1 && oob) begin
            bad <= 1'b1;
          end
          addr_q <= addr_next;
          v2     <= v1 && !oob;
          v3     <= v2;
          if (v3) begin
            sum <= sum_next;
          end
          if (!issue && !v1 && !v2 && !v3) begin
            state <= ST_QOUT;
          end
        end
        // Hand the score to the result register when it is free
        ST_QOUT: begin
          if (!out_valid || result.ready) begin
            out_valid   <= 1'b1;
            out_score   <= bad ? '0 : sum;
            out_invalid <= bad;
            state       <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_invalid) |-> (out_score == '0))
    else $error("invalid placement carries a nonzero score");

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    32'(mcount) <= MODEL_CAP)
    else $error("model point count beyond capacity");

  a_pipe_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (!v1 && !v2 && !v3))
    else $error("query pipeline busy while idle");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (item.valid && item.ready && (item.mode != MODE_MODEL) && (item.mode != MODE_IMAGE)
     && (item.mode != MODE_QUERY)) |=> item.ready)
    else $error("ignored mode did not return to idle");
`endif

endmodule

`default_nettype wire

FILE: rtl/cms_cfg_regs.sv
// Configuration registers of the chamfer scoring block, with side clamping
// and registered pixel totals. Depends on cms_pkg.
`default_nettype none

module cms_cfg_regs import cms_pkg::*; #(
  parameter int MAX_IMAGE_SIDE = 64,
  parameter int MAX_MODEL_SIDE = 32,
  localparam int ISW = $clog2(MAX_IMAGE_SIDE + 1),
  localparam int MSW = $clog2(MAX_MODEL_SIDE + 1),
  localparam int ITW = $clog2(MAX_IMAGE_SIDE * MAX_IMAGE_SIDE + 1),
  localparam int MTW = $clog2(MAX_MODEL_SIDE * MAX_MODEL_SIDE + 1)
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  wr_en,
  input  wire logic [CFG_IDX_W-1:0]  wr_idx,
  input  wire logic [CFG_DATA_W-1:0] wr_data,
  output logic      [ISW-1:0]        irows,
  output logic      [ISW-1:0]        icols,
  output logic      [MSW-1:0]        mrows,
  output logic      [MSW-1:0]        mcols,
  output logic      [ITW-1:0]        itotal,
  output logic      [MTW-1:0]        mtotal
);

  logic [6:0]     image_rows;
  logic [6:0]     image_cols;
  logic [5:0]     model_rows;
  logic [5:0]     model_cols;
  logic [ISW-1:0] c_irows;
  logic [ISW-1:0] c_icols;
  logic [MSW-1:0] c_mrows;
  logic [MSW-1:0] c_mcols;

  // Take register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      image_rows <= 7'd64;
      image_cols <= 7'd64;
      model_rows <= 6'd32;
      model_cols <= 6'd32;
    end else if (wr_en) begin
      case (wr_idx)
        REG_IMAGE_ROWS: image_rows <= wr_data;
        REG_IMAGE_COLS: image_cols <= wr_data;
        REG_MODEL_ROWS: model_rows <= wr_data[5:0];
        REG_MODEL_COLS: model_cols <= wr_data[5:0];
        default: ;
      endcase
    end
  end

  // Clamp each side into [1, max]
  always_comb begin
    c_irows = (image_rows == '0) ? ISW'(1) :
              (32'(image_rows) > MAX_IMAGE_SIDE) ? ISW'(MAX_IMAGE_SIDE) : ISW'(image_rows);
    c_icols = (image_cols == '0) ? ISW'(1) :
              (32'(image_cols) > MAX_IMAGE_SIDE) ? ISW'(MAX_IMAGE_SIDE) : ISW'(image_cols);
    c_mrows = (model_rows == '0) ? MSW'(1) :
              (32'(model_rows) > MAX_MODEL_SIDE) ? MSW'(MAX_MODEL_SIDE) : MSW'(model_rows);
    c_mcols = (model_cols == '0) ? MSW'(1) :
              (32'(model_cols) > MAX_MODEL_SIDE) ? MSW'(MAX_MODEL_SIDE) : MSW'(model_cols);
  end

  // Register clamped sides and pixel totals
  always_ff @(posedge clk) begin
    irows  <= c_irows;
    icols  <= c_icols;
    mrows  <= c_mrows;
    mcols  <= c_mcols;
    itotal <= ITW'(c_irows) * ITW'(c_icols);
    mtotal <= MTW'(c_mrows) * MTW'(c_mcols);
  end

endmodule

`default_nettype wire
